@@ sv/rcdt_pkg.sv @@
// Shared types and constants of the RC discharge sensor timer.
package rcdt_pkg;

  localparam int unsigned CH_NUM   = 6;   // measuring lanes
  localparam int unsigned OUT_NUM  = 6;   // time result ports
  localparam int unsigned LVL_W    = 6;   // width of the sensor level field
  localparam int unsigned TIME_W   = 12;
  localparam int unsigned CHARGE_W = 8;
  localparam int unsigned CFG_W    = 12;

  localparam logic [TIME_W-1:0]   TIMEOUT_RST = TIME_W'(2000);
  localparam logic [CHARGE_W-1:0] CHARGE_RST  = CHARGE_W'(10);

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_CHARGE  = 1'b1;

  // Per-transaction commands from the sequencer to every lane.
  typedef struct packed {
    logic              preset;
    logic              sample;
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] timeout;
  } lane_ctl_t;

  // Status flags of one result transaction.
  typedef struct packed {
    logic drive;
    logic meas;
    logic done;
  } flags_t;

  typedef struct packed {
    flags_t                         flags;
    logic [CH_NUM-1:0][TIME_W-1:0]  times;
  } result_t;

endpackage

@@ sv/rcdt_ctrl.sv @@
// Phase sequencer, tick counter and configuration registers.
module rcdt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rcdt_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          acc_i,
  input  logic                          start_req_i,
  output rcdt_pkg::lane_ctl_t           lane_ctl_o,
  output rcdt_pkg::flags_t              flags_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CHARGE,
    PH_MEASURE
  } phase_e;

  phase_e                             phase_q, phase_d;
  logic [rcdt_pkg::TIME_W-1:0]        tick_q, tick_d;
  logic [rcdt_pkg::TIME_W-1:0]        timeout_q;
  logic [rcdt_pkg::CHARGE_W-1:0]      charge_q;
  logic [rcdt_pkg::TIME_W-1:0]        charge_len;
  logic [rcdt_pkg::TIME_W-1:0]        tick_inc;
  logic [rcdt_pkg::TIME_W-1:0]        meas_next;
  logic                               sample;
  logic                               preset;
  rcdt_pkg::flags_t                   flags;

  // A zero charge length behaves as one tick.
  assign charge_len = (charge_q == '0) ? rcdt_pkg::TIME_W'(1)
                                       : rcdt_pkg::TIME_W'(charge_q);
  assign tick_inc   = tick_q + rcdt_pkg::TIME_W'(1);
  assign sample     = (phase_q == PH_MEASURE) && (tick_q < timeout_q);
  assign meas_next  = sample ? tick_inc : tick_q;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    preset  = 1'b0;
    flags   = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          preset      = 1'b1;
          flags.drive = 1'b1;
          // The start tick is the first charge tick.
          if (rcdt_pkg::TIME_W'(1) >= charge_len) begin
            phase_d = PH_MEASURE;
            tick_d  = '0;
          end else begin
            phase_d = PH_CHARGE;
            tick_d  = rcdt_pkg::TIME_W'(1);
          end
        end
      end
      PH_CHARGE: begin
        flags.drive = 1'b1;
        if (tick_inc >= charge_len) begin
          phase_d = PH_MEASURE;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_MEASURE: begin
        flags.meas = 1'b1;
        if (meas_next >= timeout_q) begin
          flags.done = 1'b1;
          phase_d    = PH_IDLE;
          tick_d     = '0;
        end else begin
          tick_d = meas_next;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      timeout_q <= rcdt_pkg::TIMEOUT_RST;
      charge_q  <= rcdt_pkg::CHARGE_RST;
    end else begin
      if (acc_i) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rcdt_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i[rcdt_pkg::TIME_W-1:0];
          rcdt_pkg::CFG_CHARGE:  charge_q  <= cfg_data_i[rcdt_pkg::CHARGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign lane_ctl_o.preset  = preset;
  assign lane_ctl_o.sample  = sample;
  assign lane_ctl_o.tick    = tick_q;
  assign lane_ctl_o.timeout = timeout_q;
  assign flags_o            = flags;

endmodule

@@ sv/rcdt_lane.sv @@
// One measuring lane: holds and updates the capture time of one sensor line.
module rcdt_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  rcdt_pkg::lane_ctl_t           ctl_i,
  input  logic                          level_i,
  output logic [rcdt_pkg::TIME_W-1:0]   time_o
);

  logic [rcdt_pkg::TIME_W-1:0] cap_q, cap_d;

  // The first low sample wins because later counts are never below it.
  always_comb begin
    cap_d = cap_q;
    if (ctl_i.preset) begin
      cap_d = ctl_i.timeout;
    end else if (ctl_i.sample && !level_i && (ctl_i.tick < cap_q)) begin
      cap_d = ctl_i.tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (acc_i) begin
      cap_q <= cap_d;
    end
  end

  // The result carries the value after this transaction's update.
  assign time_o = cap_d;

endmodule

@@ sv/rcdt_merge.sv @@
// Merges lane times and flags into one result and buffers it with a skid stage.
module rcdt_merge (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    acc_i,
  input  rcdt_pkg::flags_t                        flags_i,
  input  logic [rcdt_pkg::CH_NUM-1:0][rcdt_pkg::TIME_W-1:0] times_i,
  output logic                                    full_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output rcdt_pkg::result_t                       res_o
);

  rcdt_pkg::result_t new_res;
  rcdt_pkg::result_t main_q, skid_q;
  logic              main_v_q, skid_v_q;
  logic              take;

  assign new_res.flags = flags_i;
  assign new_res.times = times_i;
  assign take          = main_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (take) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          main_v_q <= acc_i;
        end
      end else if (!main_v_q) begin
        main_v_q <= acc_i;
      end else if (acc_i) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && skid_v_q) begin
      main_q <= skid_q;
    end else if (acc_i && (take || !main_v_q)) begin
      main_q <= new_res;
    end
    if (acc_i && main_v_q && !take) begin
      skid_q <= new_res;
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign res_o       = main_q;

endmodule

@@ sv/rc_discharge_sensor_timer_top.sv @@
// An accepted result is registered in the main stage, or in the skid stage while main waits.
// Throughput: one transaction per cycle unless stalled; each lane does one compare per tick
// and the shared tick counter advances at most once per transaction.
// A two-entry output buffer lets input continue while a result waits.
// Reset (asynchronous, active low) sets the idle phase, zero count, zero
// capture times, timeout 2000 and charge length 10, and empties the buffer.
module rc_discharge_sensor_timer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [rcdt_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               start_req_i,
  input  logic [rcdt_pkg::LVL_W-1:0]         sensor_levels_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               charge_drive_o,
  output logic                               measuring_o,
  output logic                               done_res_o,
  output logic [rcdt_pkg::TIME_W-1:0]        time_0_o,
  output logic [rcdt_pkg::TIME_W-1:0]        time_1_o,
  output logic [rcdt_pkg::TIME_W-1:0]        time_2_o,
  output logic [rcdt_pkg::TIME_W-1:0]        time_3_o,
  output logic [rcdt_pkg::TIME_W-1:0]        time_4_o,
  output logic [rcdt_pkg::TIME_W-1:0]        time_5_o
);

  logic                                               full;
  logic                                               acc;
  rcdt_pkg::lane_ctl_t                                lane_ctl;
  rcdt_pkg::flags_t                                   flags;
  logic [rcdt_pkg::CH_NUM-1:0][rcdt_pkg::TIME_W-1:0]  lane_times;
  rcdt_pkg::result_t                                  res;
  logic [rcdt_pkg::OUT_NUM-1:0][rcdt_pkg::TIME_W-1:0] out_times;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  rcdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .start_req_i (start_req_i),
    .lane_ctl_o  (lane_ctl),
    .flags_o     (flags)
  );

  for (genvar g = 0; g < rcdt_pkg::CH_NUM; g++) begin : g_lane
    logic level;
    // Lines beyond the level field read as low.
    if (g < rcdt_pkg::LVL_W) begin : g_in
      assign level = sensor_levels_i[g];
    end else begin : g_low
      assign level = 1'b0;
    end
    rcdt_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .acc_i   (acc),
      .ctl_i   (lane_ctl),
      .level_i (level),
      .time_o  (lane_times[g])
    );
  end

  rcdt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .flags_i     (flags),
    .times_i     (lane_times),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  for (genvar g = 0; g < rcdt_pkg::OUT_NUM; g++) begin : g_out
    if (g < rcdt_pkg::CH_NUM) begin : g_ch
      assign out_times[g] = res.times[g];
    end else begin : g_zero
      assign out_times[g] = '0;
    end
  end

  assign charge_drive_o = res.flags.drive;
  assign measuring_o    = res.flags.meas;
  assign done_res_o     = res.flags.done;
  assign time_0_o       = out_times[0];
  assign time_1_o       = out_times[1];
  assign time_2_o       = out_times[2];
  assign time_3_o       = out_times[3];
  assign time_4_o       = out_times[4];
  assign time_5_o       = out_times[5];

endmodule
